// ===== hw/rtl/lcdseq_pkg.sv =====
// Shared types and constants for the character LCD command sequencer.
// No dependencies; every other file but lcdseq_if refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

   // Operation codes of the request channel
   typedef enum logic [3:0] {
      OP_WRITE_CHAR = 4'd0,
      OP_CLEAR      = 4'd1,
      OP_SET_CURSOR = 4'd2,
      OP_RIGHT      = 4'd3,
      OP_LEFT       = 4'd4,
      OP_BLINK_ON   = 4'd5,
      OP_BLINK_OFF  = 4'd6,
      OP_GLYPH      = 4'd7,
      OP_INIT       = 4'd8
   } op_type;

   // Shape of the byte run a queued job expands into
   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_GLYPH  = 2'd1,
      JOB_INIT   = 2'd2
   } job_kind_type;

   localparam int unsigned IDX_W = 4;

   localparam logic [IDX_W-1:0] GLYPH_LAST_IDX = 4'd9;
   localparam logic [IDX_W-1:0] INIT_LAST_IDX  = 4'd5;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_RIGHT      = 8'h14;
   localparam logic [7:0] CMD_LEFT       = 8'h10;
   localparam logic [7:0] CMD_BLINK_ON   = 8'h0F;
   localparam logic [7:0] CMD_BLINK_OFF  = 8'h0E;
   localparam logic [7:0] CMD_CGRAM      = 8'h40;
   localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

   localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

   localparam logic [7:0] INIT_SEQ [6] = '{
      CMD_FUNC_8BIT, CMD_FUNC_8BIT, CMD_FUNC_8BIT,
      CMD_DISPLAY_ON, CMD_CLEAR, CMD_ENTRY_MODE
   };

   // One classified operation waiting for the back end
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   first_byte;
      logic         first_data;
      logic [63:0]  glyph_rows;
      logic [7:0]   tail_byte;
      logic [1:0]   row;
      logic [4:0]   column;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lcdseq_if.sv =====
// Valid/ready channel interfaces for requests and bus-byte responses.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lcdseq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [7:0]  char_code;
   logic [1:0]  target_row;
   logic [4:0]  target_column;
   logic [2:0]  glyph_slot;
   logic [63:0] glyph_rows;

   modport source (
      output valid, operation, char_code, target_row, target_column,
             glyph_slot, glyph_rows,
      input  ready
   );
   modport sink (
      input  valid, operation, char_code, target_row, target_column,
             glyph_slot, glyph_rows,
      output ready
   );
endinterface

interface lcdseq_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bus_byte;
   logic       is_data;
   logic       last_of_run;
   logic [1:0] cursor_row_now;
   logic [4:0] cursor_column_now;

   modport source (
      output valid, bus_byte, is_data, last_of_run, cursor_row_now,
             cursor_column_now,
      input  ready
   );
   modport sink (
      input  valid, bus_byte, is_data, last_of_run, cursor_row_now,
             cursor_column_now,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/lcdseq_front.sv =====
// Front end: accepts requests, tracks the cursor and classifies each
// operation into a job. Depends on lcdseq_pkg and lcdseq_if.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_front #(
   parameter int unsigned ROWS    = 4,
   parameter int unsigned COLUMNS = 20
) (
   input  wire                    clock,
   input  wire                    reset,
   lcdseq_req_if.sink             req_ch,
   input  lcdseq_pkg::q_status_type q_status,
   output logic                   push,
   output lcdseq_pkg::job_type    job
);

   localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);
   localparam logic [4:0] LAST_COL = 5'(COLUMNS - 1);

   logic [1:0] row_ff, row_in;
   logic [4:0] col_ff, col_in;
   logic       accept;
   logic       known;
   logic [1:0] trow;
   logic [4:0] tcol;
   logic [1:0] adv_row;
   logic [4:0] adv_col;
   logic [7:0] here_cmd;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept && known;

   always_comb begin
      trow = (req_ch.target_row > LAST_ROW) ? LAST_ROW : req_ch.target_row;
      tcol = (req_ch.target_column > LAST_COL) ? LAST_COL : req_ch.target_column;

      // advance: wrap to the next row, and past the last row to home
      if (col_ff == LAST_COL) begin
         adv_col = 5'd0;
         adv_row = (row_ff == LAST_ROW) ? 2'd0 : row_ff + 2'd1;
      end else begin
         adv_col = col_ff + 5'd1;
         adv_row = row_ff;
      end

      here_cmd = lcdseq_pkg::ROW_BASE[row_ff] + {3'b000, col_ff};
   end

   always_comb begin
      known           = 1'b1;
      row_in          = row_ff;
      col_in          = col_ff;
      job.kind        = lcdseq_pkg::JOB_SINGLE;
      job.first_byte  = 8'h00;
      job.first_data  = 1'b0;
      job.glyph_rows  = req_ch.glyph_rows;
      job.tail_byte   = here_cmd;
      unique case (lcdseq_pkg::op_type'(req_ch.operation))
         lcdseq_pkg::OP_WRITE_CHAR: begin
            job.first_byte = req_ch.char_code;
            job.first_data = 1'b1;
            row_in         = adv_row;
            col_in         = adv_col;
         end
         lcdseq_pkg::OP_CLEAR: begin
            job.first_byte = lcdseq_pkg::CMD_CLEAR;
            row_in         = 2'd0;
            col_in         = 5'd0;
         end
         lcdseq_pkg::OP_SET_CURSOR: begin
            job.first_byte = lcdseq_pkg::ROW_BASE[trow] + {3'b000, tcol};
            row_in         = trow;
            col_in         = tcol;
         end
         lcdseq_pkg::OP_RIGHT: begin
            job.first_byte = lcdseq_pkg::CMD_RIGHT;
            row_in         = adv_row;
            col_in         = adv_col;
         end
         lcdseq_pkg::OP_LEFT: begin
            job.first_byte = lcdseq_pkg::CMD_LEFT;
            if (col_ff != 5'd0) begin
               col_in = col_ff - 5'd1;
            end else if (row_ff != 2'd0) begin
               row_in = row_ff - 2'd1;
               col_in = LAST_COL;
            end
         end
         lcdseq_pkg::OP_BLINK_ON: begin
            job.first_byte = lcdseq_pkg::CMD_BLINK_ON;
         end
         lcdseq_pkg::OP_BLINK_OFF: begin
            job.first_byte = lcdseq_pkg::CMD_BLINK_OFF;
         end
         lcdseq_pkg::OP_GLYPH: begin
            job.kind       = lcdseq_pkg::JOB_GLYPH;
            job.first_byte = lcdseq_pkg::CMD_CGRAM + {2'b00, req_ch.glyph_slot, 3'b000};
         end
         lcdseq_pkg::OP_INIT: begin
            job.kind = lcdseq_pkg::JOB_INIT;
            row_in   = 2'd0;
            col_in   = 5'd0;
         end
         default: begin
            // unknown codes: take the transfer, emit nothing
            known = 1'b0;
         end
      endcase
      job.row    = row_in;
      job.column = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 2'd0;
         col_ff <= 5'd0;
      end else if (push) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdseq_queue.sv =====
// Short job queue between front and back ends.
// Depends on lcdseq_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  logic                     push,
   input  lcdseq_pkg::job_type      push_job,
   input  logic                     pop,
   output lcdseq_pkg::job_type      head_job,
   output lcdseq_pkg::q_status_type q_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lcdseq_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_count_grow : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

// ===== hw/rtl/lcdseq_back.sv =====
// Back end: expands the job at the queue head into bus bytes, one per cycle
// into the response register while it is free. Depends on lcdseq_pkg and lcdseq_if.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_back (
   input  wire                      clock,
   input  wire                      reset,
   input  lcdseq_pkg::job_type      head_job,
   input  lcdseq_pkg::q_status_type q_status,
   output logic                     pop,
   lcdseq_rsp_if.source             rsp_ch
);

   logic [lcdseq_pkg::IDX_W-1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       data_ff, data_in;
   logic       last_ff, last_in;
   logic [1:0] row_ff;
   logic [4:0] col_ff;
   logic       out_free;
   logic       fire;
   logic [2:0] row_sel;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign fire     = !q_status.empty && out_free;
   assign pop      = fire && last_in;
   assign row_sel  = 3'(idx_ff - 4'd1);

   always_comb begin
      byte_in = head_job.first_byte;
      data_in = head_job.first_data;
      last_in = 1'b1;
      unique case (head_job.kind)
         lcdseq_pkg::JOB_SINGLE: begin
         end
         lcdseq_pkg::JOB_GLYPH: begin
            last_in = (idx_ff == lcdseq_pkg::GLYPH_LAST_IDX);
            if (idx_ff == lcdseq_pkg::GLYPH_LAST_IDX) begin
               byte_in = head_job.tail_byte;
               data_in = 1'b0;
            end else if (idx_ff != '0) begin
               byte_in = head_job.glyph_rows[{row_sel, 3'b000} +: 8];
               data_in = 1'b1;
            end
         end
         lcdseq_pkg::JOB_INIT: begin
            byte_in = lcdseq_pkg::INIT_SEQ[3'(idx_ff)];
            data_in = 1'b0;
            last_in = (idx_ff == lcdseq_pkg::INIT_LAST_IDX);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff   <= last_in ? '0 : idx_ff + 1'b1;
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         data_ff <= data_in;
         last_ff <= last_in;
         row_ff  <= head_job.row;
         col_ff  <= head_job.column;
      end
   end

   assign rsp_ch.valid             = valid_ff;
   assign rsp_ch.bus_byte          = byte_ff;
   assign rsp_ch.is_data           = data_ff;
   assign rsp_ch.last_of_run       = last_ff;
   assign rsp_ch.cursor_row_now    = row_ff;
   assign rsp_ch.cursor_column_now = col_ff;

   a_run_holds_job : assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> !q_status.empty)
      else $error("byte run in progress without a job at the queue head");

   a_idx_bound : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= lcdseq_pkg::GLYPH_LAST_IDX)
      else $error("byte index beyond the longest run");

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_command_sequencer.sv =====
// Top level of the character LCD command sequencer.
// Depends on lcdseq_pkg, lcdseq_if, lcdseq_front, lcdseq_queue, lcdseq_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Content
// req_ch    in   valid/ready    operation and its operands
// rsp_ch    out  valid/ready    one bus byte with register select and cursor
//
// A request is taken whenever the job queue has room; the response
// register then yields one bus byte per cycle while the receiver keeps up:
// one byte for most operations, six for init and ten for glyph definition.
// The back end's byte sequencer sets the sustained rate; the front end keeps
// running ahead while the queue of QUEUE_DEPTH jobs absorbs response stalls.
// Reset is synchronous and homes the tracked cursor; no clearing pass needed.

module char_lcd_command_sequencer #(
   parameter int unsigned ROWS        = 4,
   parameter int unsigned COLUMNS     = 20,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire          clock,
   input  wire          reset,
   lcdseq_req_if.sink   req_ch,
   lcdseq_rsp_if.source rsp_ch
);

   // classified job from the front end, and the queue head for the back end
   lcdseq_pkg::job_type      push_job;
   lcdseq_pkg::job_type      head_job;
   lcdseq_pkg::q_status_type q_status;
   logic                     push;
   logic                     pop;

   // front: accept, track the cursor, classify
   lcdseq_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   // hold classified jobs so each side stalls on its own
   lcdseq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // back: expand the head job into bus byte transfers
   lcdseq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/tb_char_lcd_command_sequencer.sv =====
// Self-checking testbench for the character LCD command sequencer.
// Depends on lcdseq_pkg, lcdseq_if and char_lcd_command_sequencer from hw/rtl.
`timescale 1ns / 1ps

module tb_char_lcd_command_sequencer;

   // Display geometry, passed down to the block
   localparam int unsigned DISPLAY_ROWS    = 4;
   localparam int unsigned DISPLAY_COLUMNS = 20;

   // Bus command bytes
   localparam logic [7:0] LCD_CLEAR       = 8'h01;
   localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h14;
   localparam logic [7:0] LCD_SHIFT_LEFT  = 8'h10;
   localparam logic [7:0] LCD_BLINK_ON    = 8'h0F;
   localparam logic [7:0] LCD_BLINK_OFF   = 8'h0E;
   localparam logic [7:0] LCD_CGRAM_BASE  = 8'h40;
   localparam logic [7:0] LCD_FUNC_8BIT   = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] LINE_ADDRESS [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

   // Operation codes the block must ignore
   localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

   localparam logic [4:0] COLUMN_FIELD_MAX = 5'd31;

   // Run shape
   localparam int RANDOM_ITEMS    = 160;
   localparam int IDLE_PERCENT    = 16;
   localparam int QUIET_FROM      = 100;  // accepted items: no idling from here ...
   localparam int QUIET_TO        = 150;  // ... up to here
   localparam int HOLD_OFF_AFTER  = 60;   // accepted items before the long stall
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 32;

   typedef struct packed {
      logic [3:0]  operation;
      logic [7:0]  char_code;
      logic [1:0]  target_row;
      logic [4:0]  target_column;
      logic [2:0]  glyph_slot;
      logic [63:0] glyph_rows;
   } lcd_request_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_data;
      logic       last_of_run;
      logic [1:0] row;
      logic [4:0] column;
   } bus_transfer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcdseq_req_if req_ch ();
   lcdseq_rsp_if rsp_ch ();

   char_lcd_command_sequencer #(
      .ROWS    (DISPLAY_ROWS),
      .COLUMNS (DISPLAY_COLUMNS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Requests still to be offered, and bus transfers still owed by the block
   lcd_request_type  pending_requests [$];
   bus_transfer_type expected_transfers [$];
   bus_transfer_type run_stage [$];
   lcd_request_type  offered_request;

   // Cursor as the display should see it
   logic [1:0] tracked_row    = '0;
   logic [4:0] tracked_column = '0;

   int accepted_items = 0;
   int mismatch_count = 0;
   int hold_off_count = 0;

   logic quiet_stretch;
   logic holding_off;

   assign quiet_stretch = accepted_items >= QUIET_FROM && accepted_items < QUIET_TO;
   assign holding_off   = accepted_items >= HOLD_OFF_AFTER && hold_off_count < HOLD_OFF_CYCLES;

   always #1 clock = ~clock;

   // Hold every input at a known value before the first edge
   initial begin
      req_ch.valid         = 1'b0;
      req_ch.operation     = '0;
      req_ch.char_code     = '0;
      req_ch.target_row    = '0;
      req_ch.target_column = '0;
      req_ch.glyph_slot    = '0;
      req_ch.glyph_rows    = '0;
      rsp_ch.ready         = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic queue_request(input logic [3:0] op, input logic [7:0] ch,
                                input logic [1:0] row, input logic [4:0] col,
                                input logic [2:0] slot, input logic [63:0] rows);
      lcd_request_type req;
      req.operation     = op;
      req.char_code     = ch;
      req.target_row    = row;
      req.target_column = col;
      req.glyph_slot    = slot;
      req.glyph_rows    = rows;
      pending_requests.push_back(req);
   endtask

   function automatic void stage_byte(input logic [7:0] value, input logic data_flag);
      bus_transfer_type t;
      t             = '0;
      t.bus_byte    = value;
      t.is_data     = data_flag;
      run_stage.push_back(t);
   endfunction

   // Step the cursor one cell forward: wrap to the next row, then to home
   function automatic void step_forward();
      if (tracked_column == DISPLAY_COLUMNS - 1) begin
         tracked_column = '0;
         tracked_row    = (tracked_row == DISPLAY_ROWS - 1) ? 2'd0 : tracked_row + 2'd1;
      end else begin
         tracked_column = tracked_column + 5'd1;
      end
   endfunction

   // Expand one accepted request into the bus transfers it must cause. Every
   // transfer of a run carries the cursor as it stands after the operation.
   function automatic void predict_bus_run(input lcd_request_type req);
      logic [1:0]       row_clamped;
      logic [4:0]       column_clamped;
      bus_transfer_type t;
      run_stage.delete();
      case (req.operation)
         lcdseq_pkg::OP_WRITE_CHAR: begin
            stage_byte(req.char_code, 1'b1);
            step_forward();
         end
         lcdseq_pkg::OP_CLEAR: begin
            stage_byte(LCD_CLEAR, 1'b0);
            tracked_row    = '0;
            tracked_column = '0;
         end
         lcdseq_pkg::OP_SET_CURSOR: begin
            row_clamped    = (req.target_row > DISPLAY_ROWS - 1) ?
                             2'(DISPLAY_ROWS - 1) : req.target_row;
            column_clamped = (req.target_column > DISPLAY_COLUMNS - 1) ?
                             5'(DISPLAY_COLUMNS - 1) : req.target_column;
            stage_byte(LINE_ADDRESS[row_clamped] + 8'(column_clamped), 1'b0);
            tracked_row    = row_clamped;
            tracked_column = column_clamped;
         end
         lcdseq_pkg::OP_RIGHT: begin
            stage_byte(LCD_SHIFT_RIGHT, 1'b0);
            step_forward();
         end
         lcdseq_pkg::OP_LEFT: begin
            stage_byte(LCD_SHIFT_LEFT, 1'b0);
            // from column 0 drop to the end of the row above; home stays put
            if (tracked_column != 0)
               tracked_column = tracked_column - 5'd1;
            else if (tracked_row != 0) begin
               tracked_row    = tracked_row - 2'd1;
               tracked_column = 5'(DISPLAY_COLUMNS - 1);
            end
         end
         lcdseq_pkg::OP_BLINK_ON:  stage_byte(LCD_BLINK_ON, 1'b0);
         lcdseq_pkg::OP_BLINK_OFF: stage_byte(LCD_BLINK_OFF, 1'b0);
         lcdseq_pkg::OP_GLYPH: begin
            stage_byte(LCD_CGRAM_BASE + {2'b00, req.glyph_slot, 3'b000}, 1'b0);
            for (int i = 0; i < 8; i++)
               stage_byte(req.glyph_rows[8*i +: 8], 1'b1);
            stage_byte(LINE_ADDRESS[tracked_row] + 8'(tracked_column), 1'b0);
         end
         lcdseq_pkg::OP_INIT: begin
            stage_byte(LCD_FUNC_8BIT, 1'b0);
            stage_byte(LCD_FUNC_8BIT, 1'b0);
            stage_byte(LCD_FUNC_8BIT, 1'b0);
            stage_byte(LCD_DISPLAY_ON, 1'b0);
            stage_byte(LCD_CLEAR, 1'b0);
            stage_byte(LCD_ENTRY_MODE, 1'b0);
            tracked_row    = '0;
            tracked_column = '0;
         end
         default: ;  // unknown codes: no transfer, cursor untouched
      endcase
      for (int i = 0; i < run_stage.size(); i++) begin
         t             = run_stage[i];
         t.last_of_run = (i == run_stage.size() - 1);
         t.row         = tracked_row;
         t.column      = tracked_column;
         expected_transfers.push_back(t);
      end
   endfunction

   // Driver: predict on each accepted transfer, then offer the next request
   // only once the current one has gone (or nothing was on offer).
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_bus_run(offered_request);
            accepted_items <= accepted_items + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 &&
                !(!quiet_stretch && $urandom_range(99) < IDLE_PERCENT)) begin
               offered_request       = pending_requests.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.operation     <= offered_request.operation;
               req_ch.char_code     <= offered_request.char_code;
               req_ch.target_row    <= offered_request.target_row;
               req_ch.target_column <= offered_request.target_column;
               req_ch.glyph_slot    <= offered_request.glyph_slot;
               req_ch.glyph_rows    <= offered_request.glyph_rows;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver stall: count it out once the run is well under way, so
   // the job queue fills and the block pushes back on the request side
   always @(posedge clock) begin
      if (reset)
         hold_off_count <= 0;
      else if (holding_off)
         hold_off_count <= hold_off_count + 1;
   end

   // Monitor: compare each bus transfer with the oldest expectation
   always @(posedge clock) begin
      bus_transfer_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_transfers.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer, byte %h", rsp_ch.bus_byte));
            end else begin
               want = expected_transfers.pop_front();
               if (rsp_ch.bus_byte !== want.bus_byte)
                  report_mismatch($sformatf("bus_byte %h, wanted %h",
                                            rsp_ch.bus_byte, want.bus_byte));
               if (rsp_ch.is_data !== want.is_data)
                  report_mismatch($sformatf("is_data %b, wanted %b (byte %h)",
                                            rsp_ch.is_data, want.is_data, want.bus_byte));
               if (rsp_ch.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, wanted %b (byte %h)",
                                            rsp_ch.last_of_run, want.last_of_run,
                                            want.bus_byte));
               if (rsp_ch.cursor_row_now !== want.row)
                  report_mismatch($sformatf("cursor row %0d, wanted %0d",
                                            rsp_ch.cursor_row_now, want.row));
               if (rsp_ch.cursor_column_now !== want.column)
                  report_mismatch($sformatf("cursor column %0d, wanted %0d",
                                            rsp_ch.cursor_column_now, want.column));
            end
         end
         rsp_ch.ready <= !holding_off &&
                         !(!quiet_stretch && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Stimulus and end of run
   initial begin
      int         counted;
      int         roll;
      logic [3:0] op;
      logic [4:0] col;

      // Directed: power-up, extremes of the data byte, both wraps forward,
      // left from home and from column 0, clamped columns, glyph slots at
      // both ends, blink, clear and the codes the block must ignore
      queue_request(lcdseq_pkg::OP_INIT, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_WRITE_CHAR, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_WRITE_CHAR, 8'hFF, 2'd3, 5'd31, 3'd7, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd3, 5'd19, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_RIGHT, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_LEFT, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd1, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_LEFT, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd2, COLUMN_FIELD_MAX, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd0, 5'd20, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_GLYPH, 8'h00, 2'd0, 5'd0, 3'd7, {64{1'b1}});
      queue_request(lcdseq_pkg::OP_GLYPH, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd2, 5'd7, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_GLYPH, 8'h00, 2'd0, 5'd0, 3'd3, 64'h1F11_0E04_1B0A_150E);
      queue_request(lcdseq_pkg::OP_BLINK_ON, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_BLINK_OFF, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_CLEAR, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(OP_UNKNOWN_LO, 8'hA5, 2'd1, 5'd3, 3'd2, {64{1'b1}});
      queue_request(OP_UNKNOWN_HI, 8'h5A, 2'd2, 5'd9, 3'd5, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd0, 5'd19, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_WRITE_CHAR, 8'h41, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd3, 5'd19, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_WRITE_CHAR, 8'h7E, 2'd0, 5'd0, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_SET_CURSOR, 8'h00, 2'd1, 5'd5, 3'd0, 64'h0);
      queue_request(lcdseq_pkg::OP_LEFT, 8'h00, 2'd0, 5'd0, 3'd0, 64'h0);

      // Random: mostly character writes and cursor moves so the cursor sweeps
      // the whole display; every field is filled whatever the operation
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 35)      op = lcdseq_pkg::OP_WRITE_CHAR;
         else if (roll < 45) op = lcdseq_pkg::OP_SET_CURSOR;
         else if (roll < 55) op = lcdseq_pkg::OP_RIGHT;
         else if (roll < 67) op = lcdseq_pkg::OP_LEFT;
         else if (roll < 72) op = lcdseq_pkg::OP_BLINK_ON;
         else if (roll < 77) op = lcdseq_pkg::OP_BLINK_OFF;
         else if (roll < 85) op = lcdseq_pkg::OP_GLYPH;
         else if (roll < 89) op = lcdseq_pkg::OP_CLEAR;
         else if (roll < 93) op = lcdseq_pkg::OP_INIT;
         else                op = 4'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
         col = ($urandom_range(99) < 85) ? 5'($urandom_range(DISPLAY_COLUMNS - 1, 0))
                                         : 5'($urandom_range(COLUMN_FIELD_MAX, DISPLAY_COLUMNS));
         queue_request(op, 8'($urandom_range(255, 0)), 2'($urandom_range(3, 0)), col,
                       3'($urandom_range(7, 0)), {$urandom, $urandom});
         if (op <= lcdseq_pkg::OP_INIT)
            counted++;
      end

      // Drain: every request taken, every transfer seen, then a short grace
      // period to catch anything the block sends on its own
      while (reset)
         @(posedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_transfers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
